// ----- src/crgb_pkg.sv -----
// crgb_pkg: shared widths, coefficients, codes and the command and status
// structs of the congruential generator bank; no dependencies
`timescale 1ns / 1ps

package crgb_pkg;

  // default parameter values
  localparam int VALUE_WIDTH_DEF = 16;
  localparam int SUM_TERMS_DEF   = 12;

  // fixed field widths
  localparam int MOD_W      = 16;
  localparam int MODE_W     = 3;
  localparam int SEED_W     = 16;
  localparam int OUT_W      = 20;
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // register reset value and minimum modulus
  localparam logic [MOD_W-1:0]  MODULUS_RST = 16'd65521;
  localparam logic [MOD_W-1:0]  MODULUS_MIN = 16'd2;

  // recurrence coefficients
  localparam int LIN_MUL  = 28;
  localparam int LIN_ADD  = 76;
  localparam int QUAD_SQ  = 16;
  localparam int QUAD_LIN = 33;
  localparam int QUAD_ADD = 47;
  localparam int INV_MUL  = 49;
  localparam int INV_ADD  = 30;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 1'd1;

  // generator modes
  typedef logic [MODE_W-1:0] mode_t;
  localparam mode_t MODE_LINEAR = 3'd0;
  localparam mode_t MODE_QUAD   = 3'd1;
  localparam mode_t MODE_FIB    = 3'd2;
  localparam mode_t MODE_INV    = 3'd3;
  localparam mode_t MODE_DIFF   = 3'd4;
  localparam mode_t MODE_NORMAL = 3'd5;

  // dividend sources of the reduction unit
  typedef logic [2:0] src_t;
  localparam src_t SRC_SEED1 = 3'd0;
  localparam src_t SRC_SEED2 = 3'd1;
  localparam src_t SRC_LIN   = 3'd2;
  localparam src_t SRC_CUR   = 3'd3;
  localparam src_t SRC_POLY  = 3'd4;
  localparam src_t SRC_FIB   = 3'd5;
  localparam src_t SRC_AFF   = 3'd6;

  // destinations of a finished remainder
  typedef logic [2:0] dst_t;
  localparam dst_t DST_CUR     = 3'd0;
  localparam dst_t DST_PREV    = 3'd1;
  localparam dst_t DST_TERM    = 3'd2;
  localparam dst_t DST_FIB     = 3'd3;
  localparam dst_t DST_CUR_T   = 3'd4;
  localparam dst_t DST_CUR_SUM = 3'd5;

  // result selection
  typedef logic [1:0] res_t;
  localparam res_t RES_CUR  = 2'd0;
  localparam res_t RES_DIFF = 2'd1;
  localparam res_t RES_NORM = 2'd2;

  typedef struct packed {
    logic latch_in;
    logic red_start;
    src_t red_src;
    logic wr_en;
    dst_t wr_dst;
    logic mul_en;
    logic srch_init;
    logic srch_step;
    logic sum_clr;
    logic res_load;
    res_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic  op_load;
    mode_t mode;
    logic  red_done;
    logic  srch_end;
    logic  out_free;
  } sts_t;

endpackage

// ----- src/crgb_modred.sv -----
// crgb_modred: bit-serial modular reduction, one dividend bit per cycle
// depends on crgb_pkg for the modulus width
`timescale 1ns / 1ps

module crgb_modred #(
  parameter int DIV_W = 38
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [DIV_W-1:0]           dividend,
  input  logic [crgb_pkg::MOD_W-1:0] modulus,
  output logic                       done,
  output logic [crgb_pkg::MOD_W-1:0] rem
);

  localparam int CW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]           sh_r, sh_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [crgb_pkg::MOD_W-1:0] rem_r, rem_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [crgb_pkg::MOD_W:0]   trial;
  logic [crgb_pkg::MOD_W-1:0] rem_step;

  // remainder stays below the modulus, so the trial fits one extra bit
  always_comb begin
    trial = {rem_r, sh_r[DIV_W-1]};
    if (trial >= {1'b0, modulus}) begin
      rem_step = crgb_pkg::MOD_W'(trial - {1'b0, modulus});
    end else begin
      rem_step = trial[crgb_pkg::MOD_W-1:0];
    end
  end

  always_comb begin
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      sh_nxt   = dividend;
      cnt_nxt  = CW'(DIV_W);
      rem_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      sh_nxt  = {sh_r[DIV_W-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      rem_nxt = rem_step;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ----- src/crgb_datapath.sv -----
// crgb_datapath: configuration registers, generator state, reduction unit,
// squarer, inverse search, twelve-sum accumulator and output register
// depends on crgb_pkg and crgb_modred
`timescale 1ns / 1ps

module crgb_datapath #(
  parameter int VALUE_WIDTH = crgb_pkg::VALUE_WIDTH_DEF,
  parameter int SUM_TERMS   = crgb_pkg::SUM_TERMS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  crgb_pkg::cmd_t                  cmd,
  output crgb_pkg::sts_t                  sts,
  input  logic [crgb_pkg::IN_DATA_W-1:0]  in_data,
  input  logic [crgb_pkg::IN_USER_W-1:0]  in_user,
  input  logic                            cfg_we,
  input  logic [crgb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crgb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [crgb_pkg::OUT_W-1:0]      out_data
);

  localparam int MW     = crgb_pkg::MOD_W;
  localparam int VW     = VALUE_WIDTH;
  localparam int DIV_W  = (VALUE_WIDTH + 6 > 38) ? VALUE_WIDTH + 6 : 38;
  localparam int SUM_W  = crgb_pkg::MOD_W + $clog2(SUM_TERMS + 1);
  localparam int DIFF_W = ((SUM_W > crgb_pkg::OUT_W) ? SUM_W : crgb_pkg::OUT_W) + 1;

  logic [MW-1:0]                  modulus_r;
  crgb_pkg::mode_t                mode_r;
  logic [MW-1:0]                  m_eff;
  logic [VW-1:0]                  cur_r, cur_nxt;
  logic [VW-1:0]                  prev_r, prev_nxt;
  logic [VW-1:0]                  t_r;
  logic [crgb_pkg::SEED_W-1:0]    seed1_r, seed2_r;
  logic [MW-1:0]                  term_r;
  logic [2*MW-1:0]                sq_r;
  logic [MW-1:0]                  acc_r, idx_r, inv_r;
  logic [MW:0]                    acc_sum;
  logic [MW-1:0]                  acc_add;
  logic                           srch_hit, srch_last;
  logic [SUM_W-1:0]               sum_r;
  logic [DIV_W-1:0]               dividend;
  logic                           red_done;
  logic [MW-1:0]                  red_rem;
  logic [VW-1:0]                  rem_vw;
  logic [VW-1:0]                  abs_diff;
  logic [DIFF_W-1:0]              ofs_full, norm_val;
  logic [crgb_pkg::OUT_W-1:0]     res_val;
  logic [crgb_pkg::OUT_W-1:0]     res_r;
  logic                           out_valid_r;

  // a modulus of zero or one acts as two
  assign m_eff = (modulus_r < crgb_pkg::MODULUS_MIN) ? crgb_pkg::MODULUS_MIN : modulus_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= crgb_pkg::MODULUS_RST;
      mode_r    <= crgb_pkg::MODE_LINEAR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        crgb_pkg::REG_MODULUS: modulus_r <= cfg_data;
        crgb_pkg::REG_MODE:    mode_r    <= cfg_data[crgb_pkg::MODE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cmd.red_src)
      crgb_pkg::SRC_SEED1: dividend = DIV_W'(seed1_r);
      crgb_pkg::SRC_SEED2: dividend = DIV_W'(seed2_r);
      crgb_pkg::SRC_LIN:
        dividend = DIV_W'(cur_r) * DIV_W'(crgb_pkg::LIN_MUL) + DIV_W'(crgb_pkg::LIN_ADD);
      crgb_pkg::SRC_POLY:
        dividend = DIV_W'(sq_r) * DIV_W'(crgb_pkg::QUAD_SQ)
                 + DIV_W'(term_r) * DIV_W'(crgb_pkg::QUAD_LIN)
                 + DIV_W'(crgb_pkg::QUAD_ADD);
      crgb_pkg::SRC_FIB:   dividend = DIV_W'(cur_r) + DIV_W'(prev_r);
      crgb_pkg::SRC_AFF:
        dividend = DIV_W'(inv_r) * DIV_W'(crgb_pkg::INV_MUL) + DIV_W'(crgb_pkg::INV_ADD);
      default:             dividend = DIV_W'(cur_r);
    endcase
  end

  crgb_modred #(
    .DIV_W(DIV_W)
  ) u_modred (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.red_start),
    .dividend(dividend),
    .modulus (m_eff),
    .done    (red_done),
    .rem     (red_rem)
  );

  // new state words are masked to the state width
  assign rem_vw = VW'(red_rem);

  always_comb begin
    cur_nxt  = cur_r;
    prev_nxt = prev_r;
    if (cmd.wr_en) begin
      unique case (cmd.wr_dst) inside
        crgb_pkg::DST_CUR, crgb_pkg::DST_CUR_T, crgb_pkg::DST_CUR_SUM: cur_nxt = rem_vw;
        crgb_pkg::DST_PREV: prev_nxt = rem_vw;
        crgb_pkg::DST_FIB: begin
          cur_nxt  = rem_vw;
          prev_nxt = cur_r;
        end
        default: cur_nxt = cur_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= '0;
      prev_r <= '0;
    end else begin
      cur_r  <= cur_nxt;
      prev_r <= prev_nxt;
    end
  end

  // inverse search: acc tracks term * idx mod m
  assign acc_sum   = {1'b0, acc_r} + {1'b0, term_r};
  assign acc_add   = (acc_sum >= {1'b0, m_eff}) ? MW'(acc_sum - {1'b0, m_eff}) : MW'(acc_sum);
  assign srch_hit  = (acc_r == MW'(1));
  assign srch_last = (idx_r == m_eff - MW'(1));

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      seed1_r <= in_data[crgb_pkg::SEED_W-1:0];
      seed2_r <= in_data[2*crgb_pkg::SEED_W-1:crgb_pkg::SEED_W];
    end
    if (cmd.wr_en && cmd.wr_dst == crgb_pkg::DST_CUR_T) begin
      t_r <= rem_vw;
    end
    if (cmd.wr_en && cmd.wr_dst == crgb_pkg::DST_TERM) begin
      term_r <= red_rem;
    end
    if (cmd.mul_en) begin
      sq_r <= (2*MW)'(term_r) * (2*MW)'(term_r);
    end
    if (cmd.srch_init) begin
      acc_r <= term_r;
      idx_r <= MW'(1);
    end else if (cmd.srch_step) begin
      if (srch_hit) begin
        inv_r <= idx_r;
      end else if (srch_last) begin
        inv_r <= '0;
      end else begin
        acc_r <= acc_add;
        idx_r <= idx_r + MW'(1);
      end
    end
    if (cmd.sum_clr) begin
      sum_r <= '0;
    end else if (cmd.wr_en && cmd.wr_dst == crgb_pkg::DST_CUR_SUM) begin
      sum_r <= sum_r + SUM_W'(rem_vw);
    end
  end

  assign abs_diff = (t_r > cur_r) ? (t_r - cur_r) : (cur_r - t_r);
  assign ofs_full = (DIFF_W'(m_eff) * DIFF_W'(SUM_TERMS)) >> 1;
  assign norm_val = DIFF_W'(sum_r) - ofs_full;

  always_comb begin
    unique case (cmd.res_sel)
      crgb_pkg::RES_DIFF: res_val = crgb_pkg::OUT_W'(abs_diff);
      crgb_pkg::RES_NORM: res_val = crgb_pkg::OUT_W'(norm_val);
      default:            res_val = crgb_pkg::OUT_W'(cur_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_r <= res_val;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  assign sts.op_load  = in_user[0];
  assign sts.mode     = mode_r;
  assign sts.red_done = red_done;
  assign sts.srch_end = srch_hit || srch_last;
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

// ----- src/crgb_ctrl.sv -----
// crgb_ctrl: sequencer that steps each generator mode through reductions,
// squaring, inverse search and result hand-off; depends on crgb_pkg
`timescale 1ns / 1ps

module crgb_ctrl #(
  parameter int SUM_TERMS = crgb_pkg::SUM_TERMS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  crgb_pkg::sts_t sts,
  output crgb_pkg::cmd_t cmd
);

  localparam int KW = $clog2(SUM_TERMS + 1);
  localparam logic [KW-1:0] K_LAST = KW'(SUM_TERMS - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LD1   = 4'd1;
  localparam logic [3:0] S_LD2   = 4'd2;
  localparam logic [3:0] S_LIN   = 4'd3;
  localparam logic [3:0] S_QRED  = 4'd4;
  localparam logic [3:0] S_QMUL  = 4'd5;
  localparam logic [3:0] S_QPOLY = 4'd6;
  localparam logic [3:0] S_FIB   = 4'd7;
  localparam logic [3:0] S_SINIT = 4'd8;
  localparam logic [3:0] S_SRCH  = 4'd9;
  localparam logic [3:0] S_IAFF  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0]    state_r, state_nxt;
  logic          issued_r, issued_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic          is_red;
  logic [3:0]    red_next;

  always_comb begin
    state_nxt  = state_r;
    issued_nxt = issued_r;
    k_nxt      = k_r;
    cmd        = '0;
    in_ready   = 1'b0;
    is_red     = 1'b0;
    red_next   = S_IDLE;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          if (sts.op_load) begin
            state_nxt = S_LD1;
          end else begin
            cmd.sum_clr = 1'b1;
            k_nxt       = '0;
            unique case (sts.mode) inside
              crgb_pkg::MODE_QUAD, crgb_pkg::MODE_INV, crgb_pkg::MODE_NORMAL:
                state_nxt = S_QRED;
              crgb_pkg::MODE_FIB: state_nxt = S_FIB;
              default:            state_nxt = S_LIN;
            endcase
          end
        end
      end
      S_LD1: begin
        is_red      = 1'b1;
        cmd.red_src = crgb_pkg::SRC_SEED1;
        cmd.wr_dst  = crgb_pkg::DST_CUR;
        red_next    = S_LD2;
      end
      S_LD2: begin
        is_red      = 1'b1;
        cmd.red_src = crgb_pkg::SRC_SEED2;
        cmd.wr_dst  = crgb_pkg::DST_PREV;
        red_next    = S_IDLE;
      end
      S_LIN: begin
        is_red      = 1'b1;
        cmd.red_src = crgb_pkg::SRC_LIN;
        cmd.wr_dst  = crgb_pkg::DST_CUR_T;
        red_next    = (sts.mode == crgb_pkg::MODE_DIFF) ? S_QRED : S_OUT;
      end
      S_QRED: begin
        is_red      = 1'b1;
        cmd.red_src = crgb_pkg::SRC_CUR;
        cmd.wr_dst  = crgb_pkg::DST_TERM;
        if (sts.mode == crgb_pkg::MODE_QUAD || sts.mode == crgb_pkg::MODE_DIFF) begin
          red_next = S_QMUL;
        end else begin
          red_next = S_SINIT;
        end
      end
      S_QMUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_QPOLY;
      end
      S_QPOLY: begin
        is_red      = 1'b1;
        cmd.red_src = crgb_pkg::SRC_POLY;
        cmd.wr_dst  = crgb_pkg::DST_CUR;
        red_next    = S_OUT;
      end
      S_FIB: begin
        is_red      = 1'b1;
        cmd.red_src = crgb_pkg::SRC_FIB;
        cmd.wr_dst  = crgb_pkg::DST_FIB;
        red_next    = S_OUT;
      end
      S_SINIT: begin
        cmd.srch_init = 1'b1;
        state_nxt     = S_SRCH;
      end
      S_SRCH: begin
        cmd.srch_step = 1'b1;
        if (sts.srch_end) begin
          state_nxt = S_IAFF;
        end
      end
      S_IAFF: begin
        is_red      = 1'b1;
        cmd.red_src = crgb_pkg::SRC_AFF;
        cmd.wr_dst  = crgb_pkg::DST_CUR_SUM;
        // the twelve-sum mode loops back for its next inverse term
        if (sts.mode == crgb_pkg::MODE_NORMAL && k_r != K_LAST) begin
          red_next = S_QRED;
        end else begin
          red_next = S_OUT;
        end
        if (issued_r && sts.red_done) begin
          k_nxt = k_r + KW'(1);
        end
      end
      S_OUT: begin
        if (sts.mode == crgb_pkg::MODE_DIFF) begin
          cmd.res_sel = crgb_pkg::RES_DIFF;
        end else if (sts.mode == crgb_pkg::MODE_NORMAL) begin
          cmd.res_sel = crgb_pkg::RES_NORM;
        end else begin
          cmd.res_sel = crgb_pkg::RES_CUR;
        end
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // reduction states: kick the unit once, then wait for its remainder
    if (is_red) begin
      if (!issued_r) begin
        cmd.red_start = 1'b1;
        issued_nxt    = 1'b1;
      end else if (sts.red_done) begin
        cmd.wr_en  = 1'b1;
        issued_nxt = 1'b0;
        state_nxt  = red_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      issued_r <= 1'b0;
      k_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      issued_r <= issued_nxt;
      k_r      <= k_nxt;
    end
  end

endmodule

// ----- src/congruential_random_generator_bank_core.sv -----
// congruential_random_generator_bank_core: controller plus datapath, one item at a time.
// each modular reduction takes one dividend bit per cycle; a load reduces both seeds, a linear
// or fibonacci value takes one reduction, quadratic reduces, squares and reduces again,
// difference does the linear then the quadratic step, inverse mode adds a search and an affine
// step, the twelve-sum mode repeats reduce, search and affine step SUM_TERMS times; the next
// transaction can be taken after the result is loaded. synchronous active-low reset: modulus 65521, mode 0.
`timescale 1ns / 1ps

module congruential_random_generator_bank_core #(
  parameter int VALUE_WIDTH = crgb_pkg::VALUE_WIDTH_DEF,
  parameter int SUM_TERMS   = crgb_pkg::SUM_TERMS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // seed_first [15:0], seed_second [31:16]
  input  logic [crgb_pkg::IN_DATA_W-1:0]   in_tdata,
  // operation [0]
  input  logic [crgb_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // random_value [19:0], zero fill [23:20]
  output logic [crgb_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [crgb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [crgb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  crgb_pkg::cmd_t             cmd;
  crgb_pkg::sts_t             sts;
  logic [crgb_pkg::OUT_W-1:0] out_data;

  assign cfg_ready = 1'b1;

  crgb_ctrl #(
    .SUM_TERMS(SUM_TERMS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  crgb_datapath #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .SUM_TERMS  (SUM_TERMS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_tdata),
    .in_user  (in_tuser),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .out_ready(out_tready),
    .out_valid(out_tvalid),
    .out_data (out_data)
  );

  assign out_tdata = crgb_pkg::OUT_DATA_W'(out_data);

  // an accepted transaction always takes the sequencer out of idle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  // no result can be ready the cycle after an item is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result appeared without any reduction");

  // once the inverse is resolved the search stops
  a_search_stops: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.srch_step && sts.srch_end |=> !cmd.srch_step)
    else $error("inverse search ran past its end");

endmodule

// ----- tb/tb_congruential_random_generator_bank_core.sv -----
// tb_congruential_random_generator_bank_core: self-checking testbench of the generator bank
// core; predicts every generated value and compares it with the result stream
// depends on crgb_pkg and congruential_random_generator_bank_core
`timescale 1ns / 1ps

module tb_congruential_random_generator_bank_core;
  import crgb_pkg::*;

  localparam int     CLK_HALF_NS   = 4;
  localparam int     MAX_GAP       = 14;
  localparam int     HOLD_CYCLES   = 300;
  localparam int     SETTLE_CYCLES = 200;
  localparam int     MAX_REPORTS   = 10;
  localparam int     NUM_TERMS     = SUM_TERMS_DEF;
  localparam int     RAND_PHASES   = 6;
  localparam int     PHASE_ITEMS   = 10;
  localparam longint TIMEOUT_NS    = 30_000_000;

  localparam logic  OP_PRODUCE   = 1'b0;
  localparam logic  OP_LOAD      = 1'b1;
  localparam mode_t MODE_SPARE_A = 3'd6;
  localparam mode_t MODE_SPARE_B = 3'd7;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // shadow of the block's registers and state words
  logic [MOD_W-1:0]  cfg_modulus = MODULUS_RST;
  mode_t             cfg_mode    = MODE_LINEAR;
  longint unsigned   cur_word    = 0;
  longint unsigned   prev_word   = 0;

  logic [OUT_W-1:0]  pending_randoms[$];
  int                mismatch_count = 0;
  int                results_seen   = 0;
  int                loads_seen     = 0;
  bit                in_idle_en     = 1'b1;
  bit                out_idle_en    = 1'b1;
  bit                hold_off_req   = 1'b0;

  congruential_random_generator_bank_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #CLK_HALF_NS clk = 1'b1;
    #CLK_HALF_NS clk = 1'b0;
  end

  function automatic int draw_gap(bit enable);
    return enable ? int'($urandom_range(0, MAX_GAP)) : 0;
  endfunction

  // extended euclid; zero when v shares a factor with m
  function automatic longint unsigned mod_inverse_of(longint unsigned v, longint unsigned m);
    longint mm, r0, r1, t0, t1, q, nr, nt;
    mm = m;
    r0 = mm;
    r1 = v % m;
    t0 = 0;
    t1 = 1;
    while (r1 != 0) begin
      q  = r0 / r1;
      nr = r0 - q * r1;
      nt = t0 - q * t1;
      r0 = r1;
      r1 = nr;
      t0 = t1;
      t1 = nt;
    end
    if (r0 != 1) return 0;
    t0 = t0 % mm;
    if (t0 < 0) t0 = t0 + mm;
    return t0;
  endfunction

  function automatic longint unsigned linear_step(longint unsigned m);
    cur_word = (LIN_MUL * cur_word + LIN_ADD) % m;
    return cur_word;
  endfunction

  function automatic longint unsigned quadratic_step(longint unsigned m);
    longint unsigned c;
    c = cur_word % m;
    cur_word = (QUAD_SQ * c * c + QUAD_LIN * c + QUAD_ADD) % m;
    return cur_word;
  endfunction

  function automatic longint unsigned inverse_step(longint unsigned m);
    cur_word = (INV_MUL * mod_inverse_of(cur_word, m) + INV_ADD) % m;
    return cur_word;
  endfunction

  // applies one accepted item to the shadow state and queues the value it yields
  function automatic void advance_generator(logic op, logic [SEED_W-1:0] s1,
                                            logic [SEED_W-1:0] s2);
    longint unsigned m, r, t, u, sum, old;
    m = (cfg_modulus < MODULUS_MIN) ? MODULUS_MIN : cfg_modulus;
    if (op == OP_LOAD) begin
      cur_word  = s1 % m;
      prev_word = s2 % m;
      loads_seen++;
    end else begin
      case (cfg_mode)
        MODE_QUAD: r = quadratic_step(m);
        MODE_FIB: begin
          old       = cur_word;
          cur_word  = (cur_word + prev_word) % m;
          prev_word = old;
          r         = cur_word;
        end
        MODE_INV: r = inverse_step(m);
        MODE_DIFF: begin
          t = linear_step(m);
          u = quadratic_step(m);
          r = (t > u) ? t - u : u - t;
        end
        MODE_NORMAL: begin
          sum = 0;
          for (int k = 0; k < NUM_TERMS; k++) sum += inverse_step(m);
          r = sum - (NUM_TERMS * m) / 2;
        end
        default: r = linear_step(m);
      endcase
      pending_randoms.push_back(r[OUT_W-1:0]);
    end
  endfunction

  task automatic send_item(logic op, logic [SEED_W-1:0] s1, logic [SEED_W-1:0] s2);
    int gap;
    gap = draw_gap(in_idle_en);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {s2, s1};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    advance_generator(op, s1, s2);
  endtask

  // a trailing load gives no result, so the settle time covers its reductions
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_randoms.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] mod_val, logic [CFG_DATA_W-1:0] mode_val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= REG_MODULUS;
    cfg_data  <= mod_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_modulus = mod_val;
    cfg_index <= REG_MODE;
    cfg_data  <= mode_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_mode = mode_val[MODE_W-1:0];
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_values();
    repeat (2) send_item(OP_PRODUCE, '0, '0);
  endtask

  task automatic test_linear_quadratic();
    configure(16'hFFFF, CFG_DATA_W'(MODE_LINEAR));
    send_item(OP_LOAD, 16'hFFFF, 16'hFFFF);
    send_item(OP_PRODUCE, 16'hFFFF, 16'h0000);
    configure(16'hFFFF, CFG_DATA_W'(MODE_QUAD));
    send_item(OP_PRODUCE, 16'h0000, 16'hFFFF);
    send_item(OP_PRODUCE, 16'hA5A5, 16'h5A5A);
  endtask

  task automatic test_fibonacci();
    configure(16'hFFFF, CFG_DATA_W'(MODE_FIB));
    send_item(OP_LOAD, 16'hFFFE, 16'hFFFD);
    repeat (3) send_item(OP_PRODUCE, 16'h0000, 16'h0000);
  endtask

  task automatic test_inverse();
    configure(16'hFFFF, CFG_DATA_W'(MODE_INV));
    send_item(OP_LOAD, 16'd2, 16'd0);
    repeat (2) send_item(OP_PRODUCE, 16'h0000, 16'h0000);
    // modulus one acts as two; zero has no inverse
    configure(16'd1, CFG_DATA_W'(MODE_INV));
    send_item(OP_PRODUCE, 16'h0000, 16'h0000);
  endtask

  task automatic test_difference();
    configure(16'd65521, CFG_DATA_W'(MODE_DIFF));
    send_item(OP_LOAD, 16'h1234, 16'h0000);
    repeat (2) send_item(OP_PRODUCE, 16'h0000, 16'h0000);
  endtask

  task automatic test_twelve_sum();
    configure(16'd0, CFG_DATA_W'(MODE_NORMAL));
    send_item(OP_PRODUCE, 16'h0000, 16'h0000);
    configure(16'd397, CFG_DATA_W'(MODE_NORMAL));
    send_item(OP_LOAD, 16'($urandom), 16'($urandom));
    repeat (2) send_item(OP_PRODUCE, 16'h0000, 16'h0000);
  endtask

  // upper data bits of the mode register are don't care
  task automatic test_unused_modes();
    configure(16'd1000, {13'h1FFF, MODE_SPARE_A});
    send_item(OP_PRODUCE, 16'h0000, 16'h0000);
    configure(16'hFFFF, {13'h0AAA, MODE_SPARE_B});
    send_item(OP_PRODUCE, 16'h0000, 16'h0000);
  endtask

  // state seeded under a wide modulus, then stepped under a narrow one
  task automatic test_stale_state();
    configure(16'hFFFF, CFG_DATA_W'(MODE_FIB));
    send_item(OP_LOAD, 16'd65000, 16'd60000);
    configure(16'd100, CFG_DATA_W'(MODE_FIB));
    repeat (2) send_item(OP_PRODUCE, 16'h0000, 16'h0000);
  endtask

  task automatic test_back_pressure();
    configure(16'd65521, CFG_DATA_W'(MODE_LINEAR));
    in_idle_en   = 1'b0;
    hold_off_req = 1'b1;
    repeat (8) send_item(OP_PRODUCE, 16'($urandom), 16'($urandom));
    drain();
    in_idle_en = 1'b1;
  endtask

  task automatic test_random();
    mode_t            mode;
    logic [MOD_W-1:0] mod_val;
    logic             op;
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      mode = mode_t'($urandom_range(0, 7));
      // search-based modes get small moduli to bound the run
      case (mode)
        MODE_INV:    mod_val = MOD_W'($urandom_range(0, 3000));
        MODE_NORMAL: mod_val = MOD_W'($urandom_range(0, 300));
        default:     mod_val = ($urandom_range(0, 3) == 0) ? MOD_W'($urandom_range(0, 20))
                                                           : MOD_W'($urandom_range(0, 65535));
      endcase
      configure(mod_val, CFG_DATA_W'(mode));
      in_idle_en  = ($urandom_range(0, 3) != 0);
      out_idle_en = ($urandom_range(0, 3) != 0);
      send_item(OP_LOAD, 16'($urandom), 16'($urandom));
      repeat (PHASE_ITEMS) begin
        op = ($urandom_range(0, 7) == 0) ? OP_LOAD : OP_PRODUCE;
        send_item(op, 16'($urandom), 16'($urandom));
      end
    end
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
  endtask

  // result sink: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      stall = draw_gap(out_idle_en);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid || hold_off_req));
    end
  end

  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_randoms.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("unexpected result transaction: random_value %0h", out_tdata[OUT_W-1:0]);
        mismatch_count++;
      end else begin
        want = pending_randoms.pop_front();
        if (out_tdata[OUT_W-1:0] !== want) begin
          if (mismatch_count < MAX_REPORTS)
            $display("random_value mismatch: expected %0h actual %0h (mode %0d modulus %0d)",
                     want, out_tdata[OUT_W-1:0], cfg_mode, cfg_modulus);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d results outstanding", pending_randoms.size());
    $display("congruential_random_generator_bank_core regression: fail");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_linear_quadratic();
    test_fibonacci();
    test_inverse();
    test_difference();
    test_twelve_sum();
    test_unused_modes();
    test_stale_state();
    test_back_pressure();
    test_random();
    drain();
    if (pending_randoms.size() != 0) begin
      $display("%0d expected results never arrived", pending_randoms.size());
      mismatch_count += pending_randoms.size();
    end
    $display("checked %0d generated values and %0d seed loads across all eight mode codes,",
             results_seen, loads_seen);
    $display("moduli from 0 to 65535, random stalls and one long output hold-off");
    if (mismatch_count == 0) begin
      $display("congruential_random_generator_bank_core regression: pass");
    end else begin
      $display("congruential_random_generator_bank_core regression: fail");
    end
    $finish;
  end

endmodule
